[hw/rtl/gie_pkg.sv]
// ----------------------------------------------------------------------------
// gie_pkg: shared definitions for the GPR instruction execute core
// Operation codes, cycle costs, decode classes and fixed widths used by the
// front end, the instruction queue and the back end.
// ----------------------------------------------------------------------------
package gie_pkg;

   // Fixed field widths.
   localparam int MODE_W    = 4;
   localparam int REG_IDX_W = 5;
   localparam int DATA_W    = 32;
   localparam int TARGET_W  = 6;
   localparam int BIDX_W    = 6;
   localparam int BYTE_W    = 8;
   localparam int PC_OUT_W  = 6;
   localparam int COST_W    = 4;

   // Width used to compare small indexes against the depth parameters.
   localparam int CMP_W     = 11;

   // Default sizes and the fixed register file size.
   localparam int DEF_PROGRAM_DEPTH = 64;
   localparam int DEF_STRING_DEPTH  = 64;
   localparam int REG_COUNT         = 32;

   // Depth of the queue between front and back end.
   localparam int QUEUE_DEPTH = 4;

   // Operation codes.
   localparam logic [MODE_W-1:0] MODE_ADDI    = 4'd0;
   localparam logic [MODE_W-1:0] MODE_B       = 4'd1;
   localparam logic [MODE_W-1:0] MODE_BEQZ    = 4'd2;
   localparam logic [MODE_W-1:0] MODE_BGE     = 4'd3;
   localparam logic [MODE_W-1:0] MODE_BNE     = 4'd4;
   localparam logic [MODE_W-1:0] MODE_LA      = 4'd5;
   localparam logic [MODE_W-1:0] MODE_LB      = 4'd6;
   localparam logic [MODE_W-1:0] MODE_LI      = 4'd7;
   localparam logic [MODE_W-1:0] MODE_SUBI    = 4'd8;
   localparam logic [MODE_W-1:0] MODE_SYSCALL = 4'd9;
   localparam logic [MODE_W-1:0] MODE_HALT    = 4'd10;
   localparam logic [MODE_W-1:0] MODE_STB     = 4'd11;

   // Cycle cost of each counted operation.
   localparam logic [COST_W-1:0] COST_NONE    = 4'd0;
   localparam logic [COST_W-1:0] COST_ADDI    = 4'd6;
   localparam logic [COST_W-1:0] COST_SUBI    = 4'd6;
   localparam logic [COST_W-1:0] COST_LB      = 4'd6;
   localparam logic [COST_W-1:0] COST_B       = 4'd4;
   localparam logic [COST_W-1:0] COST_BGE     = 4'd5;
   localparam logic [COST_W-1:0] COST_BNE     = 4'd5;
   localparam logic [COST_W-1:0] COST_LA      = 4'd5;
   localparam logic [COST_W-1:0] COST_LI      = 4'd3;
   localparam logic [COST_W-1:0] COST_SYSCALL = 4'd8;

   // Syscall service register, argument register and print service number.
   localparam logic [REG_IDX_W-1:0] SVC_REG   = 5'd29;
   localparam logic [REG_IDX_W-1:0] ARG_REG   = 5'd31;
   localparam logic [DATA_W-1:0]    SVC_PRINT = 32'd1;

   // Source of the value written to the destination register.
   typedef enum logic [1:0] {
      RES_ADD  = 2'd0,
      RES_SUB  = 2'd1,
      RES_IMM  = 2'd2,
      RES_BYTE = 2'd3
   } res_sel_type;

   // Branch condition class.
   typedef enum logic [2:0] {
      BR_NONE   = 3'd0,
      BR_ALWAYS = 3'd1,
      BR_EQZ    = 3'd2,
      BR_GE     = 3'd3,
      BR_NE     = 3'd4
   } br_type;

   // Decode class of one instruction, built by the front end.
   typedef struct packed {
      logic                store_byte;
      logic                store_ok;
      logic                halt;
      logic                wr_reg;
      logic                syscall;
      logic                counted;
      res_sel_type         res_sel;
      br_type              br;
      logic [COST_W-1:0]   cost;
   } ctl_type;

endpackage

[hw/rtl/gpr_instruction_execute_core.sv]
// ----------------------------------------------------------------------------
// gpr_instruction_execute_core: pre-decoded instruction execute core
// Executes one decoded instruction per beat against a register file, a
// program counter and a byte string store, and returns one result beat.
//
//   Channel   Ports                          Direction   Beat
//   request   req_valid / req_stall, req_*   in          one instruction
//   response  rsp_valid / rsp_stall, rsp_*   out         one result
//
// One instruction is taken per cycle when nothing stalls; each request beat
// goes through the queue, then register read, then store read, then commit
// into the response register. The register file and string store ports and
// the single commit stage set that rate. After reset a clearing pass zeroes
// both stores; req_stall is high during it. Response stalls freeze the back
// end, and the request side keeps taking beats until the queue of four is
// full.
// ----------------------------------------------------------------------------
module gpr_instruction_execute_core #(
   parameter int PROGRAM_DEPTH = gie_pkg::DEF_PROGRAM_DEPTH,
   parameter int STRING_DEPTH  = gie_pkg::DEF_STRING_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [gie_pkg::MODE_W-1:0]        req_mode,
   input  logic [gie_pkg::REG_IDX_W-1:0]     req_dest_reg,
   input  logic [gie_pkg::REG_IDX_W-1:0]     req_src_reg,
   input  logic [gie_pkg::REG_IDX_W-1:0]     req_src2_reg,
   input  logic signed [gie_pkg::DATA_W-1:0] req_immediate,
   input  logic [gie_pkg::TARGET_W-1:0]      req_target,
   input  logic [gie_pkg::BIDX_W-1:0]        req_byte_index,
   input  logic [gie_pkg::BYTE_W-1:0]        req_byte_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [gie_pkg::PC_OUT_W-1:0]      rsp_next_pc,
   output logic                              rsp_branch_taken,
   output logic                              rsp_halted,
   output logic                              rsp_print_valid,
   output logic signed [gie_pkg::DATA_W-1:0] rsp_print_value,
   output logic [gie_pkg::DATA_W-1:0]        rsp_cycle_total,
   output logic [gie_pkg::DATA_W-1:0]        rsp_instr_total
);

   localparam int PC_W = $clog2(PROGRAM_DEPTH);
   localparam int SI_W = $clog2(STRING_DEPTH);
   localparam int QW   = 3 * gie_pkg::REG_IDX_W + gie_pkg::DATA_W + PC_W + SI_W
                         + gie_pkg::BYTE_W;

   logic             push, push_ready, back_busy;
   gie_pkg::ctl_type push_ctl;
   logic [QW-1:0]    push_data;
   logic             pop, pop_valid;
   gie_pkg::ctl_type pop_ctl;
   logic [QW-1:0]    pop_data;

   // Front end: accept and classify.
   gie_front #(
      .PROGRAM_DEPTH (PROGRAM_DEPTH),
      .STRING_DEPTH  (STRING_DEPTH),
      .PC_W          (PC_W),
      .SI_W          (SI_W),
      .QW            (QW)
   ) u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_dest_reg   (req_dest_reg),
      .req_src_reg    (req_src_reg),
      .req_src2_reg   (req_src2_reg),
      .req_immediate  (req_immediate),
      .req_target     (req_target),
      .req_byte_index (req_byte_index),
      .req_byte_value (req_byte_value),
      .q_ready        (push_ready),
      .back_busy      (back_busy),
      .q_push         (push),
      .q_ctl          (push_ctl),
      .q_data         (push_data)
   );

   // Queue between front and back end.
   gie_queue #(
      .DATA_W (QW)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ctl   (push_ctl),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_ctl    (pop_ctl),
      .pop_data   (pop_data)
   );

   // Back end: execute and respond.
   gie_back #(
      .PROGRAM_DEPTH (PROGRAM_DEPTH),
      .STRING_DEPTH  (STRING_DEPTH),
      .PC_W          (PC_W),
      .SI_W          (SI_W),
      .QW            (QW)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (pop_valid),
      .q_ctl            (pop_ctl),
      .q_data           (pop_data),
      .q_pop            (pop),
      .busy             (back_busy),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_next_pc      (rsp_next_pc),
      .rsp_branch_taken (rsp_branch_taken),
      .rsp_halted       (rsp_halted),
      .rsp_print_valid  (rsp_print_valid),
      .rsp_print_value  (rsp_print_value),
      .rsp_cycle_total  (rsp_cycle_total),
      .rsp_instr_total  (rsp_instr_total)
   );

endmodule

[hw/rtl/gie_front.sv]
// ----------------------------------------------------------------------------
// gie_front: instruction acceptance and classification
// Takes request beats, decodes the operation into a control class, reduces
// the branch target and byte index to their stores, and pushes the entry.
// ----------------------------------------------------------------------------
module gie_front #(
   parameter int PROGRAM_DEPTH = gie_pkg::DEF_PROGRAM_DEPTH,
   parameter int STRING_DEPTH  = gie_pkg::DEF_STRING_DEPTH,
   parameter int PC_W          = $clog2(PROGRAM_DEPTH),
   parameter int SI_W          = $clog2(STRING_DEPTH),
   parameter int QW            = 3 * gie_pkg::REG_IDX_W + gie_pkg::DATA_W
                                 + PC_W + SI_W + gie_pkg::BYTE_W
) (
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [gie_pkg::MODE_W-1:0]       req_mode,
   input  logic [gie_pkg::REG_IDX_W-1:0]    req_dest_reg,
   input  logic [gie_pkg::REG_IDX_W-1:0]    req_src_reg,
   input  logic [gie_pkg::REG_IDX_W-1:0]    req_src2_reg,
   input  logic signed [gie_pkg::DATA_W-1:0] req_immediate,
   input  logic [gie_pkg::TARGET_W-1:0]     req_target,
   input  logic [gie_pkg::BIDX_W-1:0]       req_byte_index,
   input  logic [gie_pkg::BYTE_W-1:0]       req_byte_value,
   input  logic                             q_ready,
   input  logic                             back_busy,
   output logic                             q_push,
   output gie_pkg::ctl_type                 q_ctl,
   output logic [QW-1:0]                    q_data
);

   localparam int SIX_W = (SI_W > gie_pkg::BIDX_W) ? SI_W : gie_pkg::BIDX_W;

   logic [gie_pkg::CMP_W-1:0] tgt_work;
   logic [PC_W-1:0]           tgt_mod;
   logic [SIX_W-1:0]          bidx_ext;
   logic [SI_W-1:0]           str_addr;
   gie_pkg::ctl_type          ctl;

   // A beat is taken when the queue has room and the back end is not clearing.
   assign req_stall = !q_ready || back_busy;
   assign q_push    = req_valid && !req_stall;

   // Reduce the branch target modulo the program depth by repeated subtraction.
   always_comb begin
      tgt_work = gie_pkg::CMP_W'(req_target);
      for (int i = 0; i < 8; i++) begin
         if (tgt_work >= gie_pkg::CMP_W'(PROGRAM_DEPTH)) begin
            tgt_work = tgt_work - gie_pkg::CMP_W'(PROGRAM_DEPTH);
         end
      end
      tgt_mod = tgt_work[PC_W-1:0];
   end

   // Byte store position within the string store.
   assign bidx_ext = SIX_W'(req_byte_index);
   assign str_addr = bidx_ext[SI_W-1:0];

   // Operation decode into a control class.
   always_comb begin
      ctl            = '0;
      ctl.res_sel    = gie_pkg::RES_IMM;
      ctl.br         = gie_pkg::BR_NONE;
      ctl.cost       = gie_pkg::COST_NONE;
      ctl.counted    = 1'b1;
      ctl.store_ok   = gie_pkg::CMP_W'(req_byte_index) < gie_pkg::CMP_W'(STRING_DEPTH);
      unique case (req_mode)
         gie_pkg::MODE_ADDI: begin
            ctl.wr_reg  = 1'b1;
            ctl.res_sel = gie_pkg::RES_ADD;
            ctl.cost    = gie_pkg::COST_ADDI;
         end
         gie_pkg::MODE_B: begin
            ctl.br   = gie_pkg::BR_ALWAYS;
            ctl.cost = gie_pkg::COST_B;
         end
         gie_pkg::MODE_BEQZ: begin
            ctl.br      = gie_pkg::BR_EQZ;
            ctl.counted = 1'b0;
         end
         gie_pkg::MODE_BGE: begin
            ctl.br   = gie_pkg::BR_GE;
            ctl.cost = gie_pkg::COST_BGE;
         end
         gie_pkg::MODE_BNE: begin
            ctl.br   = gie_pkg::BR_NE;
            ctl.cost = gie_pkg::COST_BNE;
         end
         gie_pkg::MODE_LA: begin
            ctl.wr_reg = 1'b1;
            ctl.cost   = gie_pkg::COST_LA;
         end
         gie_pkg::MODE_LB: begin
            ctl.wr_reg  = 1'b1;
            ctl.res_sel = gie_pkg::RES_BYTE;
            ctl.cost    = gie_pkg::COST_LB;
         end
         gie_pkg::MODE_LI: begin
            ctl.wr_reg = 1'b1;
            ctl.cost   = gie_pkg::COST_LI;
         end
         gie_pkg::MODE_SUBI: begin
            ctl.wr_reg  = 1'b1;
            ctl.res_sel = gie_pkg::RES_SUB;
            ctl.cost    = gie_pkg::COST_SUBI;
         end
         gie_pkg::MODE_SYSCALL: begin
            ctl.syscall = 1'b1;
            ctl.cost    = gie_pkg::COST_SYSCALL;
         end
         gie_pkg::MODE_STB: begin
            ctl.store_byte = 1'b1;
            ctl.counted    = 1'b0;
         end
         default: begin
            // Halt and every unassigned code stop the core.
            ctl.halt    = 1'b1;
            ctl.counted = 1'b0;
         end
      endcase
   end

   // Queue entry payload.
   assign q_ctl  = ctl;
   assign q_data = {req_dest_reg, req_src_reg, req_src2_reg, $unsigned(req_immediate),
                    tgt_mod, str_addr, req_byte_value};

endmodule

[hw/rtl/gie_queue.sv]
// ----------------------------------------------------------------------------
// gie_queue: instruction queue between front and back end
// A small first-in first-out buffer of decoded entries that lets the
// request side and the execution side stall independently.
// ----------------------------------------------------------------------------
module gie_queue #(
   parameter int DATA_W = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  gie_pkg::ctl_type      push_ctl,
   input  logic [DATA_W-1:0]     push_data,
   output logic                  push_ready,
   output logic                  pop_valid,
   input  logic                  pop,
   output gie_pkg::ctl_type      pop_ctl,
   output logic [DATA_W-1:0]     pop_data
);

   localparam int QD   = gie_pkg::QUEUE_DEPTH;
   localparam int QP_W = $clog2(QD);

   gie_pkg::ctl_type  ctl_mem_ff  [QD];
   logic [DATA_W-1:0] data_mem_ff [QD];
   logic [QP_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QP_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QP_W:0]     count_ff, count_in;

   assign push_ready = count_ff != (QP_W + 1)'(QD);
   assign pop_valid  = count_ff != '0;
   assign pop_ctl    = ctl_mem_ff[rd_ptr_ff];
   assign pop_data   = data_mem_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QP_W'(QD - 1)) ? '0 : wr_ptr_ff + QP_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QP_W'(QD - 1)) ? '0 : rd_ptr_ff + QP_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + (QP_W + 1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QP_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         ctl_mem_ff[wr_ptr_ff]  <= push_ctl;
         data_mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hw/rtl/gie_back.sv]
// ----------------------------------------------------------------------------
// gie_back: instruction execution back end
// Issues queue entries into a three-step pipeline: register read, string
// store read, and commit of registers, program counter, halt flag and totals
// into the response register. Writes are forwarded to younger entries.
// ----------------------------------------------------------------------------
module gie_back #(
   parameter int PROGRAM_DEPTH = gie_pkg::DEF_PROGRAM_DEPTH,
   parameter int STRING_DEPTH  = gie_pkg::DEF_STRING_DEPTH,
   parameter int PC_W          = $clog2(PROGRAM_DEPTH),
   parameter int SI_W          = $clog2(STRING_DEPTH),
   parameter int QW            = 3 * gie_pkg::REG_IDX_W + gie_pkg::DATA_W
                                 + PC_W + SI_W + gie_pkg::BYTE_W
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   input  gie_pkg::ctl_type                  q_ctl,
   input  logic [QW-1:0]                     q_data,
   output logic                              q_pop,
   output logic                              busy,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [gie_pkg::PC_OUT_W-1:0]      rsp_next_pc,
   output logic                              rsp_branch_taken,
   output logic                              rsp_halted,
   output logic                              rsp_print_valid,
   output logic signed [gie_pkg::DATA_W-1:0] rsp_print_value,
   output logic [gie_pkg::DATA_W-1:0]        rsp_cycle_total,
   output logic [gie_pkg::DATA_W-1:0]        rsp_instr_total
);

   localparam int RW        = gie_pkg::REG_IDX_W;
   localparam int DW        = gie_pkg::DATA_W;
   localparam int BW        = gie_pkg::BYTE_W;
   localparam int CLR_DEPTH = (STRING_DEPTH > gie_pkg::REG_COUNT) ? STRING_DEPTH
                                                                  : gie_pkg::REG_COUNT;
   localparam int CLR_W     = $clog2(CLR_DEPTH);
   localparam int PCX_W     = (PC_W > gie_pkg::PC_OUT_W) ? PC_W : gie_pkg::PC_OUT_W;

   // Queue head fields.
   logic [RW-1:0]   q_dest, q_src, q_src2;
   logic [DW-1:0]   q_imm;
   logic [PC_W-1:0] q_tgt;
   logic [SI_W-1:0] q_saddr;
   logic [BW-1:0]   q_bval;

   // Architectural state and stores.
   logic [DW-1:0]   rf_mem [gie_pkg::REG_COUNT];
   logic [BW-1:0]   str_mem [STRING_DEPTH];
   logic [DW-1:0]   svc_val_ff, arg_val_ff;
   logic [PC_W-1:0] pc_ff, pc_in;
   logic            halt_ff, halt_in;
   logic [DW-1:0]   cyc_ff, cyc_in;
   logic [DW-1:0]   ins_ff, ins_in;

   // Clearing pass after reset.
   logic             clr_busy_ff;
   logic [CLR_W-1:0] clr_idx_ff;
   logic             clr_rf_hit, clr_str_hit;

   // Register read stage.
   logic             s1_vld_ff;
   gie_pkg::ctl_type s1_ctl_ff;
   logic [RW-1:0]    s1_dest_ff, s1_src_ff, s1_src2_ff;
   logic [DW-1:0]    s1_imm_ff, s1_op1_ff, s1_op2_ff;
   logic [PC_W-1:0]  s1_tgt_ff;
   logic [SI_W-1:0]  s1_saddr_ff;
   logic [BW-1:0]    s1_bval_ff;
   logic [DW-1:0]    s1_op1_fwd, s1_op2_fwd;
   logic             s1_in_range;

   // Commit stage.
   logic             s2_vld_ff;
   gie_pkg::ctl_type s2_ctl_ff;
   logic [RW-1:0]    s2_dest_ff;
   logic [DW-1:0]    s2_imm_ff, s2_op1_ff, s2_op2_ff;
   logic [PC_W-1:0]  s2_tgt_ff;
   logic [SI_W-1:0]  s2_saddr_ff;
   logic [BW-1:0]    s2_bval_ff, s2_byte_ff;

   // Commit results.
   logic            adv, issue;
   logic            active, taken, wr_cand, wr_en, pvalid;
   logic [DW-1:0]   wr_data;
   logic            rf_we;
   logic [RW-1:0]   rf_waddr;
   logic [DW-1:0]   rf_wdata;
   logic            str_we;
   logic [SI_W-1:0] str_waddr;
   logic [BW-1:0]   str_wdata;
   logic [PCX_W-1:0] pc_ext;

   // Response register.
   logic            rsp_valid_ff;
   logic [PC_W-1:0] rsp_pc_ff;
   logic            rsp_taken_ff, rsp_halt_ff, rsp_pvalid_ff;
   logic [DW-1:0]   rsp_pval_ff, rsp_cyc_ff, rsp_ins_ff;

   assign {q_dest, q_src, q_src2, q_imm, q_tgt, q_saddr, q_bval} = q_data;

   // The pipeline moves as a whole whenever the response register is free.
   assign adv   = !rsp_valid_ff || !rsp_stall;
   assign issue = adv && q_valid && !clr_busy_ff;
   assign q_pop = issue;
   assign busy  = clr_busy_ff;

   // Commit stage: an ordinary instruction does work only while not halted.
   assign active  = s2_vld_ff && !s2_ctl_ff.store_byte && !halt_ff;
   assign wr_cand = active && s2_ctl_ff.wr_reg;
   assign wr_en   = wr_cand && adv;

   always_comb begin
      case (s2_ctl_ff.res_sel)
         gie_pkg::RES_ADD:  wr_data = s2_op1_ff + s2_imm_ff;
         gie_pkg::RES_SUB:  wr_data = s2_op1_ff - s2_imm_ff;
         gie_pkg::RES_BYTE: wr_data = {{(DW - BW){s2_byte_ff[BW-1]}}, s2_byte_ff};
         default:           wr_data = s2_imm_ff;
      endcase
   end

   // Branch resolution.
   always_comb begin
      case (s2_ctl_ff.br)
         gie_pkg::BR_ALWAYS: taken = active;
         gie_pkg::BR_EQZ:    taken = active && (s2_op1_ff == '0);
         gie_pkg::BR_GE:     taken = active && ($signed(s2_op1_ff) >= $signed(s2_op2_ff));
         gie_pkg::BR_NE:     taken = active && (s2_op1_ff != s2_op2_ff);
         default:            taken = 1'b0;
      endcase
   end

   assign pvalid = active && s2_ctl_ff.syscall && (svc_val_ff == gie_pkg::SVC_PRINT);

   // Next architectural state.
   always_comb begin
      pc_in   = pc_ff;
      halt_in = halt_ff;
      cyc_in  = cyc_ff;
      ins_in  = ins_ff;
      if (active) begin
         if (taken) begin
            pc_in = s2_tgt_ff;
         end else begin
            pc_in = (pc_ff == PC_W'(PROGRAM_DEPTH - 1)) ? '0 : pc_ff + PC_W'(1);
         end
         if (s2_ctl_ff.halt) begin
            halt_in = 1'b1;
         end
         if (s2_ctl_ff.counted) begin
            cyc_in = cyc_ff + DW'(s2_ctl_ff.cost);
            ins_in = ins_ff + DW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= '0;
         halt_ff <= 1'b0;
         cyc_ff  <= '0;
         ins_ff  <= '0;
      end else if (adv && s2_vld_ff) begin
         pc_ff   <= pc_in;
         halt_ff <= halt_in;
         cyc_ff  <= cyc_in;
         ins_ff  <= ins_in;
      end
   end

   // Clearing pass over both stores after reset.
   assign clr_rf_hit  = {1'b0, clr_idx_ff} < (CLR_W + 1)'(gie_pkg::REG_COUNT);
   assign clr_str_hit = {1'b0, clr_idx_ff} < (CLR_W + 1)'(STRING_DEPTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else if (clr_busy_ff) begin
         clr_idx_ff <= clr_idx_ff + CLR_W'(1);
         if (clr_idx_ff == CLR_W'(CLR_DEPTH - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // Register file write port, shared by the clearing pass and commit.
   assign rf_we    = clr_busy_ff ? clr_rf_hit : wr_en;
   assign rf_waddr = clr_busy_ff ? clr_idx_ff[RW-1:0] : s2_dest_ff;
   assign rf_wdata = clr_busy_ff ? '0 : wr_data;

   always_ff @(posedge clock) begin
      if (rf_we) begin
         rf_mem[rf_waddr] <= rf_wdata;
      end
   end

   // Copies of the syscall service and argument registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         svc_val_ff <= '0;
         arg_val_ff <= '0;
      end else if (rf_we) begin
         if (rf_waddr == gie_pkg::SVC_REG) begin
            svc_val_ff <= rf_wdata;
         end
         if (rf_waddr == gie_pkg::ARG_REG) begin
            arg_val_ff <= rf_wdata;
         end
      end
   end

   // String store write port, shared by the clearing pass and store byte.
   assign str_we    = clr_busy_ff ? clr_str_hit
                                  : (adv && s2_vld_ff && s2_ctl_ff.store_byte
                                     && s2_ctl_ff.store_ok);
   assign str_waddr = clr_busy_ff ? clr_idx_ff[SI_W-1:0] : s2_saddr_ff;
   assign str_wdata = clr_busy_ff ? '0 : s2_bval_ff;

   always_ff @(posedge clock) begin
      if (str_we) begin
         str_mem[str_waddr] <= str_wdata;
      end
   end

   // Register read at issue, taking a same-edge commit write first.
   always_ff @(posedge clock) begin
      if (issue) begin
         s1_op1_ff <= (wr_en && s2_dest_ff == q_src) ? wr_data : rf_mem[q_src];
         s1_op2_ff <= (wr_en && s2_dest_ff == q_src2) ? wr_data : rf_mem[q_src2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_ctl_ff   <= q_ctl;
         s1_dest_ff  <= q_dest;
         s1_src_ff   <= q_src;
         s1_src2_ff  <= q_src2;
         s1_imm_ff   <= q_imm;
         s1_tgt_ff   <= q_tgt;
         s1_saddr_ff <= q_saddr;
         s1_bval_ff  <= q_bval;
      end
   end

   // Forward the commit-stage result to the entry right behind it.
   assign s1_op1_fwd  = (wr_cand && s2_dest_ff == s1_src_ff) ? wr_data : s1_op1_ff;
   assign s1_op2_fwd  = (wr_cand && s2_dest_ff == s1_src2_ff) ? wr_data : s1_op2_ff;
   assign s1_in_range = s1_op1_fwd < DW'(STRING_DEPTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (adv) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   // String store read for load byte; out of range reads as zero.
   always_ff @(posedge clock) begin
      if (adv) begin
         s2_ctl_ff   <= s1_ctl_ff;
         s2_dest_ff  <= s1_dest_ff;
         s2_imm_ff   <= s1_imm_ff;
         s2_op1_ff   <= s1_op1_fwd;
         s2_op2_ff   <= s1_op2_fwd;
         s2_tgt_ff   <= s1_tgt_ff;
         s2_saddr_ff <= s1_saddr_ff;
         s2_bval_ff  <= s1_bval_ff;
         if (!s1_in_range) begin
            s2_byte_ff <= '0;
         end else if (str_we && str_waddr == s1_op1_fwd[SI_W-1:0]) begin
            s2_byte_ff <= str_wdata;
         end else begin
            s2_byte_ff <= str_mem[s1_op1_fwd[SI_W-1:0]];
         end
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && s2_vld_ff) begin
         rsp_pc_ff     <= pc_in;
         rsp_taken_ff  <= taken;
         rsp_halt_ff   <= halt_in;
         rsp_pvalid_ff <= pvalid;
         rsp_pval_ff   <= pvalid ? arg_val_ff : '0;
         rsp_cyc_ff    <= cyc_in;
         rsp_ins_ff    <= ins_in;
      end
   end

   assign pc_ext           = PCX_W'(rsp_pc_ff);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_next_pc      = pc_ext[gie_pkg::PC_OUT_W-1:0];
   assign rsp_branch_taken = rsp_taken_ff;
   assign rsp_halted       = rsp_halt_ff;
   assign rsp_print_valid  = rsp_pvalid_ff;
   assign rsp_print_value  = $signed(rsp_pval_ff);
   assign rsp_cycle_total  = rsp_cyc_ff;
   assign rsp_instr_total  = rsp_ins_ff;

endmodule

[tb/gpr_instruction_execute_core_tb.sv]
// ----------------------------------------------------------------------------
// gpr_instruction_execute_core_tb: self-checking bench for the execute core
// A predictor in the bench runs every accepted instruction beat against its
// own register file, string store, PC and totals. The expected result goes
// into a queue, and each result beat is compared field by field with the
// oldest entry. A directed pass, random passes and a halt pass are run, with
// random gaps on the request side and random stalls on the response side.
// ----------------------------------------------------------------------------
module gpr_instruction_execute_core_tb;

   // Stop after this many cycles in which no beat moves on either channel.
   localparam int QUIET_LIMIT = 4000;
   // Cycles to watch for stray results once nothing is expected.
   localparam int TAIL_CYCLES = 16;

   // One decoded instruction as it is driven on the request channel.
   typedef struct packed {
      logic [gie_pkg::MODE_W-1:0]    mode;
      logic [gie_pkg::REG_IDX_W-1:0] dest;
      logic [gie_pkg::REG_IDX_W-1:0] src;
      logic [gie_pkg::REG_IDX_W-1:0] src2;
      logic [gie_pkg::DATA_W-1:0]    imm;
      logic [gie_pkg::TARGET_W-1:0]  target;
      logic [gie_pkg::BIDX_W-1:0]    bidx;
      logic [gie_pkg::BYTE_W-1:0]    bval;
   } instr_type;

   // One result beat as the core should return it.
   typedef struct packed {
      logic [gie_pkg::PC_OUT_W-1:0] next_pc;
      logic                         taken;
      logic                         halted;
      logic                         print_valid;
      logic [gie_pkg::DATA_W-1:0]   print_value;
      logic [gie_pkg::DATA_W-1:0]   cycle_total;
      logic [gie_pkg::DATA_W-1:0]   instr_total;
   } outcome_type;

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_stall;
   logic [gie_pkg::MODE_W-1:0]        req_mode;
   logic [gie_pkg::REG_IDX_W-1:0]     req_dest_reg;
   logic [gie_pkg::REG_IDX_W-1:0]     req_src_reg;
   logic [gie_pkg::REG_IDX_W-1:0]     req_src2_reg;
   logic signed [gie_pkg::DATA_W-1:0] req_immediate;
   logic [gie_pkg::TARGET_W-1:0]      req_target;
   logic [gie_pkg::BIDX_W-1:0]        req_byte_index;
   logic [gie_pkg::BYTE_W-1:0]        req_byte_value;
   logic                              rsp_valid;
   logic                              rsp_stall;
   logic [gie_pkg::PC_OUT_W-1:0]      rsp_next_pc;
   logic                              rsp_branch_taken;
   logic                              rsp_halted;
   logic                              rsp_print_valid;
   logic signed [gie_pkg::DATA_W-1:0] rsp_print_value;
   logic [gie_pkg::DATA_W-1:0]        rsp_cycle_total;
   logic [gie_pkg::DATA_W-1:0]        rsp_instr_total;

   // Architectural state as the predictor sees it.
   logic [gie_pkg::DATA_W-1:0]   gpr [gie_pkg::REG_COUNT];
   logic [gie_pkg::BYTE_W-1:0]   str_mem [gie_pkg::DEF_STRING_DEPTH];
   logic [gie_pkg::PC_OUT_W-1:0] pc_q;
   logic [gie_pkg::DATA_W-1:0]   cycle_q;
   logic [gie_pkg::DATA_W-1:0]   instr_q;
   logic                         halted_q;

   outcome_type pending_results [$];
   bit          sender_gaps;
   int          mismatches;
   int          n_sent;
   int          n_checked;
   int          n_taken;
   int          n_prints;
   int          quiet_cycles = 0;

   gpr_instruction_execute_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_dest_reg     (req_dest_reg),
      .req_src_reg      (req_src_reg),
      .req_src2_reg     (req_src2_reg),
      .req_immediate    (req_immediate),
      .req_target       (req_target),
      .req_byte_index   (req_byte_index),
      .req_byte_value   (req_byte_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_next_pc      (rsp_next_pc),
      .rsp_branch_taken (rsp_branch_taken),
      .rsp_halted       (rsp_halted),
      .rsp_print_valid  (rsp_print_valid),
      .rsp_print_value  (rsp_print_value),
      .rsp_cycle_total  (rsp_cycle_total),
      .rsp_instr_total  (rsp_instr_total)
   );

   // Free-running clock with a period of four time units.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Idle length: mostly none, often a few cycles, now and then a long one.
   function automatic int unsigned idle_len();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick < 5) return 0;
      if (pick < 9) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Registers are drawn with extra weight on r0 and the syscall registers.
   function automatic logic [gie_pkg::REG_IDX_W-1:0] pick_reg();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return gie_pkg::SVC_REG;
         2: return gie_pkg::ARG_REG;
         default: return gie_pkg::REG_IDX_W'($urandom_range(0, gie_pkg::REG_COUNT - 1));
      endcase
   endfunction

   // Immediates: small values that make useful string addresses, their
   // negatives, full-range values and the extremes of the signed range.
   function automatic logic [gie_pkg::DATA_W-1:0] pick_imm();
      case ($urandom_range(0, 3))
         0: return gie_pkg::DATA_W'($urandom_range(0, gie_pkg::DEF_STRING_DEPTH + 6));
         1: return gie_pkg::DATA_W'(0 - $urandom_range(1, gie_pkg::DEF_STRING_DEPTH + 6));
         2: return $urandom;
         default: begin
            case ($urandom_range(0, 3))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'hFFFF_FFFF;
               default: return '0;
            endcase
         end
      endcase
   endfunction

   // A random instruction from the operations that keep the core running.
   function automatic instr_type rand_instr();
      instr_type   ins;
      int unsigned sel;
      sel = $urandom_range(0, gie_pkg::MODE_SYSCALL + 1);
      ins.mode   = (sel > gie_pkg::MODE_SYSCALL) ? gie_pkg::MODE_STB
                                                 : gie_pkg::MODE_W'(sel);
      ins.dest   = pick_reg();
      ins.src    = pick_reg();
      ins.src2   = pick_reg();
      ins.imm    = pick_imm();
      ins.target = gie_pkg::TARGET_W'($urandom_range(0, gie_pkg::DEF_PROGRAM_DEPTH - 1));
      ins.bidx   = gie_pkg::BIDX_W'($urandom_range(0, gie_pkg::DEF_STRING_DEPTH - 1));
      ins.bval   = gie_pkg::BYTE_W'($urandom_range(0, 255));
      return ins;
   endfunction

   // A directed instruction; the fields it does not use stay random.
   function automatic instr_type op(input logic [gie_pkg::MODE_W-1:0] mode,
                                    input int dest, input int src, input int src2,
                                    input logic [gie_pkg::DATA_W-1:0] imm,
                                    input int tgt);
      instr_type ins;
      ins        = rand_instr();
      ins.mode   = mode;
      ins.dest   = gie_pkg::REG_IDX_W'(dest);
      ins.src    = gie_pkg::REG_IDX_W'(src);
      ins.src2   = gie_pkg::REG_IDX_W'(src2);
      ins.imm    = imm;
      ins.target = gie_pkg::TARGET_W'(tgt);
      return ins;
   endfunction

   // A directed byte write into the string store.
   function automatic instr_type stb(input int idx, input logic [gie_pkg::BYTE_W-1:0] val);
      instr_type ins;
      ins      = rand_instr();
      ins.mode = gie_pkg::MODE_STB;
      ins.bidx = gie_pkg::BIDX_W'(idx);
      ins.bval = val;
      return ins;
   endfunction

   // Executes one instruction on the predictor state and returns the result
   // beat that the core should produce for it.
   function automatic outcome_type execute_instr(input instr_type ins);
      outcome_type                res;
      logic [gie_pkg::DATA_W-1:0] src_val;
      logic [gie_pkg::DATA_W-1:0] src2_val;
      logic [gie_pkg::BYTE_W-1:0] loaded;
      logic [gie_pkg::COST_W-1:0] cost;
      logic                       counted;
      logic                       advance;
      res      = '0;
      cost     = gie_pkg::COST_NONE;
      counted  = 1'b1;
      advance  = 1'b1;
      src_val  = gpr[ins.src];
      src2_val = gpr[ins.src2];

      // Byte writes go through even when halted and never move the PC.
      if (ins.mode == gie_pkg::MODE_STB) begin
         str_mem[ins.bidx] = ins.bval;
         advance = 1'b0;
         counted = 1'b0;
      end else if (halted_q) begin
         advance = 1'b0;
         counted = 1'b0;
      end else begin
         case (ins.mode)
            gie_pkg::MODE_ADDI: begin
               gpr[ins.dest] = src_val + ins.imm;
               cost = gie_pkg::COST_ADDI;
            end
            gie_pkg::MODE_B: begin
               res.taken = 1'b1;
               cost = gie_pkg::COST_B;
            end
            gie_pkg::MODE_BEQZ: begin
               res.taken = (src_val == '0);
               counted = 1'b0;
            end
            gie_pkg::MODE_BGE: begin
               res.taken = ($signed(src_val) >= $signed(src2_val));
               cost = gie_pkg::COST_BGE;
            end
            gie_pkg::MODE_BNE: begin
               res.taken = (src_val != src2_val);
               cost = gie_pkg::COST_BNE;
            end
            gie_pkg::MODE_LA: begin
               gpr[ins.dest] = ins.imm;
               cost = gie_pkg::COST_LA;
            end
            gie_pkg::MODE_LB: begin
               // Addresses past the store read as zero; the byte is sign-extended.
               loaded = (src_val < gie_pkg::DEF_STRING_DEPTH)
                        ? str_mem[src_val[gie_pkg::BIDX_W-1:0]] : '0;
               gpr[ins.dest] = {{(gie_pkg::DATA_W - gie_pkg::BYTE_W)
                                 {loaded[gie_pkg::BYTE_W-1]}}, loaded};
               cost = gie_pkg::COST_LB;
            end
            gie_pkg::MODE_LI: begin
               gpr[ins.dest] = ins.imm;
               cost = gie_pkg::COST_LI;
            end
            gie_pkg::MODE_SUBI: begin
               gpr[ins.dest] = src_val - ins.imm;
               cost = gie_pkg::COST_SUBI;
            end
            gie_pkg::MODE_SYSCALL: begin
               if (gpr[gie_pkg::SVC_REG] == gie_pkg::SVC_PRINT) begin
                  res.print_valid = 1'b1;
                  res.print_value = gpr[gie_pkg::ARG_REG];
               end
               cost = gie_pkg::COST_SYSCALL;
            end
            default: begin
               // Halt, and every unassigned code, stops the core.
               halted_q = 1'b1;
               counted  = 1'b0;
            end
         endcase
      end

      if (counted) begin
         cycle_q = cycle_q + gie_pkg::DATA_W'(cost);
         instr_q = instr_q + 1;
      end
      // The PC is six bits wide, so it wraps with the program depth.
      if (advance) pc_q = res.taken ? ins.target : pc_q + 1'b1;

      res.next_pc     = pc_q;
      res.halted      = halted_q;
      res.cycle_total = cycle_q;
      res.instr_total = instr_q;
      return res;
   endfunction

   // Sends one instruction beat, after a random gap when gaps are enabled,
   // and records its expected result once the core takes it.
   task automatic send_instr(input instr_type ins);
      int unsigned gap;
      outcome_type res;
      gap = sender_gaps ? idle_len() : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_mode       = ins.mode;
      req_dest_reg   = ins.dest;
      req_src_reg    = ins.src;
      req_src2_reg   = ins.src2;
      req_immediate  = ins.imm;
      req_target     = ins.target;
      req_byte_index = ins.bidx;
      req_byte_value = ins.bval;
      req_valid      = 1'b1;
      do @(posedge clock); while (req_stall);
      res = execute_instr(ins);
      pending_results.push_back(res);
      n_sent++;
      if (res.taken) n_taken++;
      if (res.print_valid) n_prints++;
   endtask

   // Holds the request side idle until every expected result has arrived.
   task automatic drain_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Reports one field that differs from its expected value.
   task automatic compare_field(input string fname,
                                input logic [gie_pkg::DATA_W-1:0] want,
                                input logic [gie_pkg::DATA_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
         mismatches++;
      end
   endtask

   // Directed cases: syscall with and without the print service, wrapping arithmetic,
   // r0 as an ordinary register, signed bge, PC wrap, lb sign extension and
   // out-of-range lb addresses, and both outcomes of every conditional branch.
   task automatic test_directed();
      sender_gaps = 1'b1;
      send_instr(op(gie_pkg::MODE_SYSCALL, 0, 0, 0, '0, 0));
      send_instr(op(gie_pkg::MODE_LI, int'(gie_pkg::ARG_REG), 0, 0, 32'h7FFF_FFFF, 0));
      send_instr(op(gie_pkg::MODE_LA, int'(gie_pkg::SVC_REG), 0, 0, gie_pkg::SVC_PRINT, 0));
      send_instr(op(gie_pkg::MODE_SYSCALL, 0, 0, 0, '0, 0));
      send_instr(op(gie_pkg::MODE_LI, 1, 0, 0, 32'h8000_0000, 0));
      send_instr(op(gie_pkg::MODE_ADDI, 2, 1, 0, 32'hFFFF_FFFF, 0));
      send_instr(op(gie_pkg::MODE_SUBI, 3, 1, 0, 32'd1, 0));
      send_instr(op(gie_pkg::MODE_ADDI, 0, 0, 0, 32'd5, 0));
      send_instr(op(gie_pkg::MODE_BGE, 0, 1, 2, '0, gie_pkg::DEF_PROGRAM_DEPTH - 1));
      send_instr(op(gie_pkg::MODE_BGE, 0, 2, 1, '0, gie_pkg::DEF_PROGRAM_DEPTH - 1));
      send_instr(op(gie_pkg::MODE_LI, 4, 0, 0, '0, 0));
      send_instr(stb(0, 8'h80));
      send_instr(stb(gie_pkg::DEF_STRING_DEPTH - 1, 8'h7F));
      send_instr(op(gie_pkg::MODE_LB, 5, 4, 0, '0, 0));
      send_instr(op(gie_pkg::MODE_LI, 6, 0, 0,
                    gie_pkg::DATA_W'(gie_pkg::DEF_STRING_DEPTH - 1), 0));
      send_instr(op(gie_pkg::MODE_LB, 7, 6, 0, '0, 0));
      send_instr(op(gie_pkg::MODE_LB, 8, 1, 0, '0, 0));
      send_instr(op(gie_pkg::MODE_LI, 9, 0, 0,
                    gie_pkg::DATA_W'(gie_pkg::DEF_STRING_DEPTH), 0));
      send_instr(op(gie_pkg::MODE_LB, 10, 9, 0, '0, 0));
      send_instr(op(gie_pkg::MODE_BEQZ, 0, 4, 0, '0, 10));
      send_instr(op(gie_pkg::MODE_BEQZ, 0, 0, 0, '0, 10));
      send_instr(op(gie_pkg::MODE_BNE, 0, 0, 4, '0, 20));
      send_instr(op(gie_pkg::MODE_BNE, 0, 4, 4, '0, 20));
      send_instr(op(gie_pkg::MODE_B, 0, 0, 0, '0, 0));
   endtask

   // Random instruction streams; now and then the syscall service register
   // is loaded with the print service or cleared.
   task automatic test_random(input int count, input bit gaps);
      instr_type ins;
      sender_gaps = gaps;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 7) == 0)
            ins = op(gie_pkg::MODE_LI, int'(gie_pkg::SVC_REG), 0, 0,
                     gie_pkg::DATA_W'($urandom_range(0, 1)), 0);
         else
            ins = rand_instr();
         send_instr(ins);
      end
   endtask

   // Stops the core with halt or an unassigned code, then checks that every
   // code leaves the state frozen while byte writes still land.
   task automatic test_halt();
      instr_type ins;
      drain_results();
      sender_gaps = 1'b1;
      ins = rand_instr();
      ins.mode = $urandom_range(0, 1) ? gie_pkg::MODE_HALT
                 : gie_pkg::MODE_W'($urandom_range(gie_pkg::MODE_STB + 1,
                                                   (1 << gie_pkg::MODE_W) - 1));
      send_instr(ins);
      for (int m = 0; m < (1 << gie_pkg::MODE_W); m++) begin
         ins = rand_instr();
         ins.mode = gie_pkg::MODE_W'(m);
         send_instr(ins);
      end
      send_instr(stb(gie_pkg::DEF_STRING_DEPTH - 1, 8'hFF));
      send_instr(op(gie_pkg::MODE_LB, 11, 6, 0, '0, 0));
   endtask

   // Response side: runs without stalls, sometimes long ones, between stalls.
   initial begin
      int unsigned run_len;
      int unsigned hold_len;
      rsp_stall = 1'b0;
      forever begin
         run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 12);
         repeat (run_len) begin
            @(negedge clock);
            rsp_stall = 1'b0;
         end
         hold_len = idle_len() + 1;
         repeat (hold_len) begin
            @(negedge clock);
            rsp_stall = 1'b1;
         end
      end
   end

   // Each result beat is checked against the oldest expected result.
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result beat with none expected, next_pc %h", $time,
                     rsp_next_pc);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            n_checked++;
            compare_field("next_pc", gie_pkg::DATA_W'(want.next_pc),
                          gie_pkg::DATA_W'(rsp_next_pc));
            compare_field("branch_taken", gie_pkg::DATA_W'(want.taken),
                          gie_pkg::DATA_W'(rsp_branch_taken));
            compare_field("halted", gie_pkg::DATA_W'(want.halted),
                          gie_pkg::DATA_W'(rsp_halted));
            compare_field("print_valid", gie_pkg::DATA_W'(want.print_valid),
                          gie_pkg::DATA_W'(rsp_print_valid));
            compare_field("print_value", want.print_value, rsp_print_value);
            compare_field("cycle_total", want.cycle_total, rsp_cycle_total);
            compare_field("instr_total", want.instr_total, rsp_instr_total);
         end
      end
   end

   // Watchdog on cycles in which no beat moves on either channel.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Main sequence.
   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_mode       = gie_pkg::MODE_ADDI;
      req_dest_reg   = '0;
      req_src_reg    = '0;
      req_src2_reg   = '0;
      req_immediate  = '0;
      req_target     = '0;
      req_byte_index = '0;
      req_byte_value = '0;
      sender_gaps    = 1'b1;
      mismatches     = 0;
      n_sent         = 0;
      n_checked      = 0;
      n_taken        = 0;
      n_prints       = 0;
      pc_q           = '0;
      cycle_q        = '0;
      instr_q        = '0;
      halted_q       = 1'b0;
      for (int r = 0; r < gie_pkg::REG_COUNT; r++) gpr[r] = '0;
      for (int s = 0; s < gie_pkg::DEF_STRING_DEPTH; s++) str_mem[s] = '0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random(150, 1'b1);
      drain_results();
      test_random(150, 1'b0);
      test_random(130, 1'b1);
      test_halt();

      // Let everything come back, then watch a little longer for strays.
      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Ran %0d instructions (directed, random and halted), checked %0d results,",
               n_sent, n_checked);
      $display("saw %0d taken branches and %0d print requests, %0d mismatches.",
               n_taken, n_prints, mismatches);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
